// File: rtl/fdem_pkg.sv
package fdem_pkg;

  localparam int unsigned EntryBytes = 32;
  localparam int unsigned NameBytes  = 11;
  localparam int unsigned PosW       = $clog2(EntryBytes);
  localparam int unsigned ApbDataW   = 64;
  localparam int unsigned ApbAddrW   = 4;

  localparam logic [PosW-1:0] PosFirst    = '0;
  localparam logic [PosW-1:0] PosLastName = PosW'(NameBytes - 1);
  localparam logic [PosW-1:0] PosAttr     = PosW'(NameBytes);
  localparam logic [PosW-1:0] PosClusHiLo = PosW'(20);
  localparam logic [PosW-1:0] PosClusHiHi = PosW'(21);
  localparam logic [PosW-1:0] PosClusLoLo = PosW'(26);
  localparam logic [PosW-1:0] PosClusLoHi = PosW'(27);
  localparam logic [PosW-1:0] PosSizeLo   = PosW'(28);
  localparam logic [PosW-1:0] PosLast     = PosW'(EntryBytes - 1);

  localparam logic [7:0] DeletedMark    = 8'hE5;
  localparam logic [7:0] LongNameAttr   = 8'h0F;
  localparam logic [7:0] VolumeLabelBit = 8'h08;

  // register select is paddr[3]: register i lies at byte address 8*i
  typedef enum logic {
    REG_NAME_FIRST_EIGHT = 1'b0,
    REG_NAME_LAST_THREE  = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    STATUS_NO_MATCH = 2'd0,
    STATUS_MATCH    = 2'd1,
    STATUS_END      = 2'd2
  } status_t;

  // character of the sought name at entry byte pos (pos below NameBytes)
  function automatic logic [7:0] name_char(input logic [63:0] first_eight,
                                           input logic [23:0] last_three,
                                           input logic [PosW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = first_eight[7:0];
      5'd1:    ch = first_eight[15:8];
      5'd2:    ch = first_eight[23:16];
      5'd3:    ch = first_eight[31:24];
      5'd4:    ch = first_eight[39:32];
      5'd5:    ch = first_eight[47:40];
      5'd6:    ch = first_eight[55:48];
      5'd7:    ch = first_eight[63:56];
      5'd8:    ch = last_three[7:0];
      5'd9:    ch = last_three[15:8];
      5'd10:   ch = last_three[23:16];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/fat_directory_entry_match_unit.sv
// FAT directory entry match unit.
// Directory bytes arrive on the input channel (in_valid/in_ready, fields scan_start
// and data_byte), one byte per transfer, and are read as 32-byte entries. Bytes 0-10
// of each entry are compared with the 8.3 name in the two APB registers (address
// 0x0: characters 0-7, address 0x8: characters 8-10). At byte 31 of each entry one
// result leaves on the output channel (out_valid/out_ready): no match, match with
// start cluster, size and attributes, or end of directory. Deleted, long-name and
// volume-label entries never match. After a match or end of directory no further
// results are given until a byte with scan_start set begins a new scan.
// Throughput is one byte per cycle; a result is presented on the cycle after byte 31
// is taken, from a single output register. While that register holds a result the
// receiver has not taken, bytes 0-30 of the next entry are still accepted; only the
// byte that would produce the next result waits for the register to drain.
// Reset clears the name registers, the byte position, the scan flags and the output
// valid flag. Configure only while no scan is in progress.
module fat_directory_entry_match_unit
  import fdem_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                scan_start,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [31:0]         start_cluster,
  output logic [31:0]         file_size,
  output logic [7:0]          attributes
);

  logic [63:0] name_first_eight;
  logic [23:0] name_last_three;

  logic [PosW-1:0] byte_position, byte_position_next;
  logic            names_equal, names_equal_next;
  logic            entry_skipped, entry_skipped_next;
  logic            directory_ended, directory_ended_next;
  logic            scan_finished, scan_finished_next;
  logic [15:0]     cluster_high_word, cluster_high_word_next;
  logic [15:0]     cluster_low_word, cluster_low_word_next;
  logic [31:0]     size_bytes, size_bytes_next;
  logic [7:0]      attribute_byte, attribute_byte_next;

  logic            in_fire;
  logic [PosW-1:0] cur_pos;
  logic            cur_finished;
  logic            result_load;
  status_t         result_status;
  logic [31:0]     result_cluster;
  logic [31:0]     result_size;
  logic [7:0]      result_attr;
  logic            cfg_write;
  reg_sel_t        cfg_sel;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_sel   = reg_sel_t'(paddr[3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_first_eight <= '0;
      name_last_three  <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_NAME_FIRST_EIGHT: name_first_eight <= pwdata;
        REG_NAME_LAST_THREE:  name_last_three  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_NAME_FIRST_EIGHT: prdata = name_first_eight;
      REG_NAME_LAST_THREE:  prdata = {{(ApbDataW-24){1'b0}}, name_last_three};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- byte scan
  assign cur_pos      = scan_start ? PosFirst : byte_position;
  assign cur_finished = scan_start ? 1'b0 : scan_finished;

  // only byte 31 can produce a result, so only that byte waits on the output
  assign in_ready = !out_valid || out_ready || (cur_pos != PosLast);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    byte_position_next     = byte_position;
    names_equal_next       = names_equal;
    entry_skipped_next     = entry_skipped;
    directory_ended_next   = directory_ended;
    scan_finished_next     = scan_finished;
    cluster_high_word_next = cluster_high_word;
    cluster_low_word_next  = cluster_low_word;
    size_bytes_next        = size_bytes;
    attribute_byte_next    = attribute_byte;
    result_load            = 1'b0;
    result_status          = STATUS_NO_MATCH;
    result_cluster         = '0;
    result_size            = '0;
    result_attr            = '0;

    if (in_fire) begin
      if (scan_start) begin
        byte_position_next   = PosFirst;
        names_equal_next     = 1'b1;
        entry_skipped_next   = 1'b0;
        directory_ended_next = 1'b0;
        scan_finished_next   = 1'b0;
      end
      if (!cur_finished) begin
        byte_position_next = cur_pos + PosW'(1);

        if (cur_pos == PosFirst) begin
          directory_ended_next = (data_byte == 8'h00);
          entry_skipped_next   = (data_byte == DeletedMark);
          names_equal_next     =
            (data_byte == name_char(name_first_eight, name_last_three, cur_pos));
        end else if (cur_pos <= PosLastName) begin
          if (data_byte != name_char(name_first_eight, name_last_three, cur_pos)) begin
            names_equal_next = 1'b0;
          end
        end else if (cur_pos == PosAttr) begin
          attribute_byte_next = data_byte;
          if (data_byte == LongNameAttr || (data_byte & VolumeLabelBit) != 8'h00) begin
            entry_skipped_next = 1'b1;
          end
        end else if (cur_pos == PosClusHiLo) begin
          cluster_high_word_next[7:0] = data_byte;
        end else if (cur_pos == PosClusHiHi) begin
          cluster_high_word_next[15:8] = data_byte;
        end else if (cur_pos == PosClusLoLo) begin
          cluster_low_word_next[7:0] = data_byte;
        end else if (cur_pos == PosClusLoHi) begin
          cluster_low_word_next[15:8] = data_byte;
        end else if (cur_pos >= PosSizeLo) begin
          size_bytes_next[{cur_pos[1:0], 3'b000} +: 8] = data_byte;
        end

        if (cur_pos == PosLast) begin
          result_load = 1'b1;
          if (directory_ended_next) begin
            result_status      = STATUS_END;
            scan_finished_next = 1'b1;
          end else if (!entry_skipped_next && names_equal_next) begin
            result_status      = STATUS_MATCH;
            result_cluster     = {cluster_high_word_next, cluster_low_word_next};
            result_size        = size_bytes_next;
            result_attr        = attribute_byte_next;
            scan_finished_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= PosFirst;
      names_equal       <= 1'b1;
      entry_skipped     <= 1'b0;
      directory_ended   <= 1'b0;
      scan_finished     <= 1'b0;
      cluster_high_word <= '0;
      cluster_low_word  <= '0;
      size_bytes        <= '0;
      attribute_byte    <= '0;
    end else begin
      byte_position     <= byte_position_next;
      names_equal       <= names_equal_next;
      entry_skipped     <= entry_skipped_next;
      directory_ended   <= directory_ended_next;
      scan_finished     <= scan_finished_next;
      cluster_high_word <= cluster_high_word_next;
      cluster_low_word  <= cluster_low_word_next;
      size_bytes        <= size_bytes_next;
      attribute_byte    <= attribute_byte_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      status        <= result_status;
      start_cluster <= result_cluster;
      file_size     <= result_size;
      attributes    <= result_attr;
    end
  end

  // ---------------------------------------------------------------- checks
  a_last_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !cur_finished && cur_pos == PosLast) |=> out_valid)
    else $error("byte 31 transfer produced no result");

  a_no_match_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_MATCH) |->
      (start_cluster == 32'd0 && file_size == 32'd0 && attributes == 8'd0))
    else $error("result without match carries non-zero fields");

  a_finished_parks_position: assert property (@(posedge clk) disable iff (rst)
    scan_finished |-> (byte_position == PosFirst))
    else $error("byte position moved after scan finished");

  a_finish_needs_final_result: assert property (@(posedge clk) disable iff (rst)
    $rose(scan_finished) |-> (out_valid && status != STATUS_NO_MATCH))
    else $error("scan finished without a match or end result");

endmodule

// File: tb/sv/fat_directory_entry_match_unit_checker.sv
`timescale 1ns / 1ps

module fat_directory_entry_match_unit_checker
  import fdem_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                scan_start,
  input  logic [7:0]          data_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          status,
  input  logic [31:0]         start_cluster,
  input  logic [31:0]         file_size,
  input  logic [7:0]          attributes,
  output int                  mismatches,
  output int                  awaited,
  output int                  results_seen
);

  typedef struct packed {
    status_t     status;
    logic [31:0] cluster;
    logic [31:0] size;
    logic [7:0]  attr;
  } entry_result_t;

  logic [63:0]     sought_low;
  logic [23:0]     sought_high;
  logic [PosW-1:0] entry_pos;
  logic            name_hit;
  logic            skip_entry;
  logic            dir_end;
  logic            scan_done;
  logic [15:0]     clus_hi;
  logic [15:0]     clus_lo;
  logic [31:0]     size_acc;
  logic [7:0]      attr_byte;
  entry_result_t   awaited_results[$];

  function automatic logic [7:0] sought_char(input logic [PosW-1:0] p);
    if (p < 8) return sought_low[8*p +: 8];
    return sought_high[8*(p-8) +: 8];
  endfunction

  // advance the entry model by one directory byte; queue the outcome at byte 31
  task automatic predict_entry_byte(input logic start, input logic [7:0] b);
    entry_result_t r;
    logic [PosW-1:0] p;
    if (start) begin
      entry_pos  = PosFirst;
      name_hit   = 1'b1;
      skip_entry = 1'b0;
      dir_end    = 1'b0;
      scan_done  = 1'b0;
    end
    if (scan_done) return;
    p = entry_pos;
    entry_pos = entry_pos + 1'b1;
    if (p == PosFirst) begin
      dir_end    = (b == 8'h00);
      skip_entry = (b == DeletedMark);
      name_hit   = (b == sought_char(p));
    end else if (p <= PosLastName) begin
      if (b != sought_char(p)) name_hit = 1'b0;
    end else if (p == PosAttr) begin
      attr_byte = b;
      if (b == LongNameAttr || (b & VolumeLabelBit) != 8'h00) skip_entry = 1'b1;
    end else if (p == PosClusHiLo) begin
      clus_hi[7:0] = b;
    end else if (p == PosClusHiHi) begin
      clus_hi[15:8] = b;
    end else if (p == PosClusLoLo) begin
      clus_lo[7:0] = b;
    end else if (p == PosClusLoHi) begin
      clus_lo[15:8] = b;
    end else if (p >= PosSizeLo) begin
      size_acc[8*(p-PosSizeLo) +: 8] = b;
    end
    if (p != PosLast) return;
    r = '0;
    r.status = STATUS_NO_MATCH;
    if (dir_end) begin
      r.status  = STATUS_END;
      scan_done = 1'b1;
    end else if (!skip_entry && name_hit) begin
      r.status  = STATUS_MATCH;
      r.cluster = {clus_hi, clus_lo};
      r.size    = size_acc;
      r.attr    = attr_byte;
      scan_done = 1'b1;
    end
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    entry_result_t want;
    if (rst) begin
      sought_low  = '0;
      sought_high = '0;
      entry_pos   = PosFirst;
      name_hit    = 1'b1;
      skip_entry  = 1'b0;
      dir_end     = 1'b0;
      scan_done   = 1'b0;
      clus_hi     = '0;
      clus_lo     = '0;
      size_acc    = '0;
      attr_byte   = '0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_sel_t'(paddr[3]))
          REG_NAME_FIRST_EIGHT: sought_low = pwdata;
          REG_NAME_LAST_THREE:  sought_high = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          $error("unexpected result transfer with status %0d", status);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
          if (start_cluster !== want.cluster) begin
            mismatches++;
            $error("start_cluster: expected %h, got %h", want.cluster, start_cluster);
          end
          if (file_size !== want.size) begin
            mismatches++;
            $error("file_size: expected %h, got %h", want.size, file_size);
          end
          if (attributes !== want.attr) begin
            mismatches++;
            $error("attributes: expected %h, got %h", want.attr, attributes);
          end
        end
      end
      if (in_valid && in_ready) predict_entry_byte(scan_start, data_byte);
    end
    awaited = awaited_results.size();
  end

endmodule

// File: tb/sv/fat_directory_entry_match_unit_tb.sv
`timescale 1ns / 1ps

module fat_directory_entry_match_unit_tb
  import fdem_pkg::*;
;

  localparam int CycleLimit          = 400000;
  localparam int RandomBytesPerPhase = 135;

  typedef enum int {
    ENT_MATCH,
    ENT_MISS,
    ENT_DELETED,
    ENT_LONG_NAME,
    ENT_VOLUME,
    ENT_END,
    ENT_RANDOM
  } entry_kind_t;

  typedef enum int { FILL_RANDOM, FILL_ONES, FILL_ZEROS } fill_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic                scan_start;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [31:0]         start_cluster;
  logic [31:0]         file_size;
  logic [7:0]          attributes;

  int mismatches;
  int awaited;
  int results_seen;

  int send_idle_pct;
  int stall_pct;
  int bytes_sent;
  int name_settings;
  int cycle_count;

  logic [7:0] sought [NameBytes];
  logic [7:0] entry_bytes [EntryBytes];

  fat_directory_entry_match_unit dut (.*);

  fat_directory_entry_match_unit_checker match_check (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apb_write(input reg_sel_t sel, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_name(input logic [63:0] first, input logic [23:0] last);
    for (int i = 0; i < 8; i++) sought[i] = first[8*i +: 8];
    for (int i = 0; i < 3; i++) sought[8+i] = last[8*i +: 8];
    apb_write(REG_NAME_FIRST_EIGHT, first);
    apb_write(REG_NAME_LAST_THREE, {40'd0, last});
    name_settings++;
  endtask

  // drop valid, drain every awaited result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_byte(input logic st, input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    scan_start <= st;
    data_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (counted) bytes_sent++;
  endtask

  task automatic build_entry(input entry_kind_t kind, input fill_t fill);
    int flip;
    for (int i = 0; i < EntryBytes; i++) begin
      case (fill)
        FILL_ONES:  entry_bytes[i] = 8'hFF;
        FILL_ZEROS: entry_bytes[i] = 8'h00;
        default:    entry_bytes[i] = 8'($urandom);
      endcase
    end
    if (kind != ENT_RANDOM)
      for (int i = 0; i < NameBytes; i++) entry_bytes[i] = sought[i];
    case (kind)
      ENT_MATCH: entry_bytes[PosAttr] &= ~VolumeLabelBit;
      ENT_MISS: begin
        entry_bytes[PosAttr] &= ~VolumeLabelBit;
        flip = $urandom_range(NameBytes - 1);
        entry_bytes[flip] ^= 8'($urandom_range(1, 255));
      end
      ENT_DELETED: begin
        entry_bytes[PosAttr] &= ~VolumeLabelBit;
        entry_bytes[PosFirst] = DeletedMark;
      end
      ENT_LONG_NAME: entry_bytes[PosAttr] = LongNameAttr;
      ENT_VOLUME:    entry_bytes[PosAttr] |= VolumeLabelBit;
      ENT_END:       entry_bytes[PosFirst] = 8'h00;
      default: ;
    endcase
  endtask

  task automatic send_entry(input logic opens_scan);
    for (int i = 0; i < EntryBytes; i++) send_byte(opens_scan && i == 0, entry_bytes[i], 1'b1);
  endtask

  function automatic fill_t pick_fill();
    case ($urandom_range(7))
      0:       return FILL_ONES;
      1:       return FILL_ZEROS;
      default: return FILL_RANDOM;
    endcase
  endfunction

  // a scan of a few non-matching entries, usually closed by a match or an end marker
  task automatic random_scan();
    int lead;
    entry_kind_t k;
    lead = $urandom_range(4);
    for (int n = 0; n < lead; n++) begin
      case ($urandom_range(4))
        0:       k = ENT_MISS;
        1:       k = ENT_DELETED;
        2:       k = ENT_LONG_NAME;
        3:       k = ENT_VOLUME;
        default: k = ENT_RANDOM;
      endcase
      build_entry(k, pick_fill());
      send_entry(n == 0);
    end
    case ($urandom_range(9))
      6, 7, 8: k = ENT_END;
      9:       k = ENT_MISS;
      default: k = ENT_MATCH;
    endcase
    build_entry(k, pick_fill());
    send_entry(lead == 0);
    repeat ($urandom_range(3)) send_byte(1'b0, 8'($urandom), 1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 40)) send_byte($urandom_range(9) == 0, 8'($urandom), 1'b1);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [63:0] first,
                           input logic [23:0] last);
    int target;
    settle();
    program_name(first, last);
    send_idle_pct = idle;
    stall_pct     = stall;
    target = bytes_sent + RandomBytesPerPhase;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) noise_burst();
      else random_scan();
    end
  endtask

  initial begin
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    scan_start = 1'b0;
    data_byte  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every kind of entry, extreme fields, restart and finished scans
    program_name(64'h2020_454D_4441_4552, 24'h54_58_54);
    build_entry(ENT_MISS, FILL_RANDOM);
    send_entry(1'b1);
    build_entry(ENT_DELETED, FILL_RANDOM);
    send_entry(1'b0);
    build_entry(ENT_LONG_NAME, FILL_RANDOM);
    send_entry(1'b0);
    build_entry(ENT_VOLUME, FILL_RANDOM);
    send_entry(1'b0);
    build_entry(ENT_MATCH, FILL_ONES);
    send_entry(1'b0);
    repeat (5) send_byte(1'b0, 8'($urandom), 1'b0);
    build_entry(ENT_MATCH, FILL_ZEROS);
    send_entry(1'b1);
    build_entry(ENT_MISS, FILL_RANDOM);
    for (int i = 0; i < 10; i++) send_byte(i == 0, entry_bytes[i], 1'b1);
    build_entry(ENT_END, FILL_ONES);
    send_entry(1'b1);
    repeat (3) send_byte(1'b0, 8'($urandom), 1'b0);
    build_entry(ENT_END, FILL_RANDOM);
    send_entry(1'b1);

    run_phase(0, 0, {$urandom, $urandom}, 24'($urandom));
    run_phase(69, 0, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF);
    run_phase(0, 69, 64'h0, 24'h0);
    run_phase(37, 37, {$urandom, $urandom}, 24'($urandom));
    run_phase(0, 0, {$urandom, $urandom} & ~64'hFF | DeletedMark, 24'($urandom));
    run_phase(69, 0, {$urandom, $urandom}, 24'($urandom));
    run_phase(0, 69, {$urandom, $urandom}, 24'($urandom));
    run_phase(37, 37, {$urandom, $urandom}, 24'($urandom));
    settle();

    $display("Streamed %0d directory bytes under %0d sought names; %0d entry results checked",
             bytes_sent, name_settings, results_seen);
    $display("Handshake modes: free-running, sender gaps, receiver stalls, both together");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fdem_pkg.sv
rtl/fat_directory_entry_match_unit.sv
tb/sv/fat_directory_entry_match_unit_checker.sv
tb/sv/fat_directory_entry_match_unit_tb.sv
